@@ hdl/sound_command_sequencer_unit_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef SOUND_COMMAND_SEQUENCER_UNIT_MACROS_SVH
`define SOUND_COMMAND_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define SCSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define SCSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/scsu_pkg.sv @@
package scsu_pkg;

    localparam int DATA_W      = 16;
    localparam int VOL_REG_W   = 8;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;
    localparam int STEP_W      = 5;

    // request kinds carried on the slave tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    // result actions carried on the master tuser
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_PLAY_ONCE = 3'd1;
    localparam logic [2:0] ACT_PLAY_REP  = 3'd2;
    localparam logic [2:0] ACT_STOP      = 3'd3;
    localparam logic [2:0] ACT_ENDED     = 3'd4;
    localparam logic [2:0] ACT_ERROR     = 3'd5;

    // script opcodes
    localparam logic [15:0] OPC_PLAY      = 16'd0;
    localparam logic [15:0] OPC_WAIT      = 16'd1;
    localparam logic [15:0] OPC_PLAY_REP  = 16'd2;
    localparam logic [15:0] OPC_PLAY_LOOP = 16'd3;
    localparam logic [15:0] OPC_DELAY     = 16'd4;
    localparam logic [15:0] OPC_DELAY_RND = 16'd5;
    localparam logic [15:0] OPC_VOLUME    = 16'd6;
    localparam logic [15:0] OPC_VOL_REL   = 16'd7;
    localparam logic [15:0] OPC_ATTEN     = 16'd8;
    localparam logic [15:0] OPC_RESTART   = 16'd9;
    localparam logic [15:0] OPC_END       = 16'd10;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [4:0] {
        U_NOP,
        U_ACCEPT,
        U_WRITE,
        U_STOP_END,
        U_STOP_KEEP,
        U_START,
        U_TICK,
        U_RD1,
        U_RD2,
        U_RD3,
        U_PLAY,
        U_WAIT,
        U_PLAY_REP,
        U_PLAY_LOOP,
        U_DELAY,
        U_RAND,
        U_RAND_FIN,
        U_VOLUME,
        U_VOL_REL,
        U_ATTEN,
        U_RESTART,
        U_END,
        U_ERROR,
        U_SEND0,
        U_SEND1
    } t_uop;

    typedef enum logic [3:0] {
        J_NEXT,
        J_GOTO,
        J_WAIT_IN,
        J_REQ,
        J_TICK,
        J_OPC,
        J_RAND,
        J_DIV,
        J_SEND0,
        J_SEND1
    } t_jmp;

    typedef struct packed {
        t_uop  uop;
        t_jmp  jmp;
        t_step target;
    } t_uword;

    // datapath flags the sequencer branches on
    typedef struct packed {
        logic        in_valid;
        logic [1:0]  req_type;
        logic        running;
        logic        delay_nz;
        logic [15:0] opcode;
        logic        hi_lt_lo;
        logic        div_busy;
        logic        out_busy;
        logic        two_results;
    } t_status;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] sid;
        logic [6:0]  vol;
        logic [7:0]  att;
    } t_result;

    localparam t_step S_ACCEPT   = 5'd0;
    localparam t_step S_REQ      = 5'd1;
    localparam t_step S_WRITE    = 5'd2;
    localparam t_step S_STOP     = 5'd3;
    localparam t_step S_START    = 5'd4;
    localparam t_step S_LOAD     = 5'd5;
    localparam t_step S_TICK     = 5'd6;
    localparam t_step S_RD1      = 5'd7;
    localparam t_step S_RD2      = 5'd8;
    localparam t_step S_RD3      = 5'd9;
    localparam t_step S_DSP      = 5'd10;
    localparam t_step S_PLAY     = 5'd11;
    localparam t_step S_WAIT     = 5'd12;
    localparam t_step S_PREP     = 5'd13;
    localparam t_step S_PLOOP    = 5'd14;
    localparam t_step S_DELAY    = 5'd15;
    localparam t_step S_RAND     = 5'd16;
    localparam t_step S_RWAIT    = 5'd17;
    localparam t_step S_RFIN     = 5'd18;
    localparam t_step S_VOL      = 5'd19;
    localparam t_step S_VREL     = 5'd20;
    localparam t_step S_ATT      = 5'd21;
    localparam t_step S_RESTART  = 5'd22;
    localparam t_step S_END      = 5'd23;
    localparam t_step S_ERR      = 5'd24;
    localparam t_step S_SEND0    = 5'd25;
    localparam t_step S_SEND1    = 5'd26;

    function automatic t_uword uw(t_uop u, t_jmp j, t_step t);
        t_uword w;
        w.uop    = u;
        w.jmp    = j;
        w.target = t;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(t_step s);
        t_uword w;
        case (s)
            S_ACCEPT:  w = uw(U_ACCEPT,    J_WAIT_IN, S_ACCEPT);
            S_REQ:     w = uw(U_NOP,       J_REQ,     S_ACCEPT);
            S_WRITE:   w = uw(U_WRITE,     J_GOTO,    S_SEND0);
            S_STOP:    w = uw(U_STOP_END,  J_GOTO,    S_SEND0);
            S_START:   w = uw(U_STOP_KEEP, J_NEXT,    S_ACCEPT);
            S_LOAD:    w = uw(U_START,     J_GOTO,    S_SEND0);
            S_TICK:    w = uw(U_TICK,      J_TICK,    S_SEND0);
            S_RD1:     w = uw(U_RD1,       J_NEXT,    S_ACCEPT);
            S_RD2:     w = uw(U_RD2,       J_NEXT,    S_ACCEPT);
            S_RD3:     w = uw(U_RD3,       J_NEXT,    S_ACCEPT);
            S_DSP:     w = uw(U_NOP,       J_OPC,     S_ACCEPT);
            S_PLAY:    w = uw(U_PLAY,      J_GOTO,    S_SEND0);
            S_WAIT:    w = uw(U_WAIT,      J_GOTO,    S_SEND0);
            S_PREP:    w = uw(U_PLAY_REP,  J_GOTO,    S_SEND0);
            S_PLOOP:   w = uw(U_PLAY_LOOP, J_GOTO,    S_SEND0);
            S_DELAY:   w = uw(U_DELAY,     J_GOTO,    S_SEND0);
            S_RAND:    w = uw(U_RAND,      J_RAND,    S_SEND0);
            S_RWAIT:   w = uw(U_NOP,       J_DIV,     S_ACCEPT);
            S_RFIN:    w = uw(U_RAND_FIN,  J_GOTO,    S_SEND0);
            S_VOL:     w = uw(U_VOLUME,    J_GOTO,    S_SEND0);
            S_VREL:    w = uw(U_VOL_REL,   J_GOTO,    S_SEND0);
            S_ATT:     w = uw(U_ATTEN,     J_GOTO,    S_SEND0);
            S_RESTART: w = uw(U_RESTART,   J_GOTO,    S_SEND0);
            S_END:     w = uw(U_END,       J_GOTO,    S_SEND0);
            S_ERR:     w = uw(U_ERROR,     J_GOTO,    S_SEND0);
            S_SEND0:   w = uw(U_SEND0,     J_SEND0,   S_ACCEPT);
            S_SEND1:   w = uw(U_SEND1,     J_SEND1,   S_ACCEPT);
            default:   w = uw(U_NOP,       J_GOTO,    S_ACCEPT);
        endcase
        return w;
    endfunction

    function automatic t_step req_entry(logic [1:0] r);
        t_step s;
        case (r)
            REQ_WRITE: s = S_WRITE;
            REQ_START: s = S_START;
            REQ_TICK:  s = S_TICK;
            default:   s = S_STOP;
        endcase
        return s;
    endfunction

    function automatic t_step op_entry(logic [15:0] op);
        t_step s;
        case (op)
            OPC_PLAY:      s = S_PLAY;
            OPC_WAIT:      s = S_WAIT;
            OPC_PLAY_REP:  s = S_PREP;
            OPC_PLAY_LOOP: s = S_PLOOP;
            OPC_DELAY:     s = S_DELAY;
            OPC_DELAY_RND: s = S_RAND;
            OPC_VOLUME:    s = S_VOL;
            OPC_VOL_REL:   s = S_VREL;
            OPC_ATTEN:     s = S_ATT;
            OPC_RESTART:   s = S_RESTART;
            OPC_END:       s = S_END;
            default:       s = S_ERR;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/scsu_ram.sv @@
module scsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/scsu_moddiv.sv @@
// Restoring remainder, one dividend bit per cycle.
module scsu_moddiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [scsu_pkg::DATA_W-1:0] i_dividend,
    input  logic [scsu_pkg::DATA_W:0]   i_divisor,
    output logic                      o_busy,
    output logic [scsu_pkg::DATA_W-1:0] o_rem
);

    localparam int CW = $clog2(scsu_pkg::DATA_W);

    logic                          r_busy;
    logic [CW-1:0]                 r_cnt;
    logic [scsu_pkg::DATA_W-1:0]   r_num;
    logic [scsu_pkg::DATA_W:0]     r_rem;
    logic [scsu_pkg::DATA_W:0]     r_den;
    logic [scsu_pkg::DATA_W+1:0]   w_trial;
    logic [scsu_pkg::DATA_W+1:0]   w_next;

    always_comb begin
        w_trial = {r_rem, r_num[scsu_pkg::DATA_W-1]};
        if (w_trial >= {1'b0, r_den}) begin
            w_next = w_trial - {1'b0, r_den};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= w_next[scsu_pkg::DATA_W:0];
            r_num <= {r_num[scsu_pkg::DATA_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(scsu_pkg::DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[scsu_pkg::DATA_W-1:0];

endmodule

@@ hdl/scsu_useq.sv @@
// Step counter over the control store, with mapped and conditional jumps.
module scsu_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scsu_pkg::t_status i_status,
    output scsu_pkg::t_uop    o_uop
);

    scsu_pkg::t_step  r_pc;
    scsu_pkg::t_step  n_pc;
    scsu_pkg::t_uword w_word;
    scsu_pkg::t_step  w_inc;

    assign w_word = scsu_pkg::ucode(r_pc);
    assign w_inc  = r_pc + 1'b1;

    always_comb begin
        case (w_word.jmp)
            scsu_pkg::J_NEXT:    n_pc = w_inc;
            scsu_pkg::J_GOTO:    n_pc = w_word.target;
            scsu_pkg::J_WAIT_IN: n_pc = i_status.in_valid ? w_inc : r_pc;
            scsu_pkg::J_REQ:     n_pc = scsu_pkg::req_entry(i_status.req_type);
            scsu_pkg::J_TICK: begin
                n_pc = (!i_status.running || i_status.delay_nz) ? w_word.target : w_inc;
            end
            scsu_pkg::J_OPC:     n_pc = scsu_pkg::op_entry(i_status.opcode);
            scsu_pkg::J_RAND:    n_pc = i_status.hi_lt_lo ? w_word.target : w_inc;
            scsu_pkg::J_DIV:     n_pc = i_status.div_busy ? r_pc : w_inc;
            scsu_pkg::J_SEND0: begin
                if (i_status.out_busy) begin
                    n_pc = r_pc;
                end else begin
                    n_pc = i_status.two_results ? w_inc : w_word.target;
                end
            end
            scsu_pkg::J_SEND1:   n_pc = i_status.out_busy ? r_pc : w_word.target;
            default:             n_pc = w_word.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= scsu_pkg::S_ACCEPT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop = w_word.uop;

endmodule

@@ hdl/sound_command_sequencer_unit.sv @@
// Sound sequence interpreter with a stream request port and a stream result port.
// Slave side: tuser selects the request (write program word, start, tick, stop);
// tdata carries the write address/word, start parameters and tick inputs.
// Master side: tuser is the action, tdata the sound, volume, attenuation and the
// looping/active flags after the request; tlast marks the final result of a request.
// Each request yields one or two results.
// A small control store steps a plain datapath; one request is taken at a time.
// A command tick makes three program memory reads through the single registered
// read port, and a random delay with a non-empty range waits on the bit-serial
// remainder unit; a second result is sent from a send step of its own.
// The output register holds a result until it is taken; the next request is
// accepted once the last result of the current one sits in that register.
// A stalled receiver holds the sequencer at its send step.
// Reset is synchronous and clears the sequencer and all sequence state; program
// memory keeps no reset value and must be written before it is run.
module sound_command_sequencer_unit #(
    parameter int PROG_DEPTH = 256,
    parameter int VOLUME_MAX = 127
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // word_addr, word_data, start_addr, start_volume, start_attenuation,
    // stop_sound_id, no_cutoff, sound_busy, random_value, zero pad
    input  logic [scsu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sound_id, volume, attenuation, looping, active, zero pad
    output logic [scsu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // action
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int AW = $clog2(PROG_DEPTH);

    function automatic logic [AW-1:0] wrap_addr8(logic [7:0] a);
        logic [15:0] r;
        r = {8'd0, a};
        for (int k = 3; k >= 0; k--) begin
            if (r >= 16'(PROG_DEPTH << k)) begin
                r = r - 16'(PROG_DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_add(logic [AW-1:0] p, logic [1:0] off);
        logic [AW:0] s;
        s = {1'b0, p} + {{(AW-1){1'b0}}, off};
        if (s >= (AW+1)'(PROG_DEPTH)) begin
            s = s - (AW+1)'(PROG_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [scsu_pkg::VOL_REG_W-1:0] clamp_vol(logic signed [17:0] v);
        logic [scsu_pkg::VOL_REG_W-1:0] c;
        if (v < 18'sd0) begin
            c = '0;
        end else if (v > $signed(18'(VOLUME_MAX))) begin
            c = scsu_pkg::VOL_REG_W'(VOLUME_MAX);
        end else begin
            c = v[scsu_pkg::VOL_REG_W-1:0];
        end
        return c;
    endfunction

    scsu_pkg::t_uop    w_uop;
    scsu_pkg::t_status w_status;

    // sequence state
    logic [AW-1:0]                  r_ptr, n_ptr;
    logic [AW-1:0]                  r_base, n_base;
    logic [15:0]                    r_cur, n_cur;
    logic [scsu_pkg::VOL_REG_W-1:0] r_vol, n_vol;
    logic [7:0]                     r_att, n_att;
    logic [15:0]                    r_delay, n_delay;
    logic                           r_loop, n_loop;
    logic                           r_run, n_run;
    logic [15:0]                    r_stop, n_stop;
    logic                           r_barred, n_barred;

    // latched request
    logic [1:0]  r_rtype;
    logic [7:0]  r_waddr;
    logic [15:0] r_wdata;
    logic [7:0]  r_saddr;
    logic [6:0]  r_svol;
    logic [7:0]  r_satt;
    logic [15:0] r_sstop;
    logic        r_snocut;
    logic        r_sbusy;
    logic [15:0] r_rnd;

    // fetched command words
    logic [15:0] r_op, n_op;
    logic [15:0] r_a1, n_a1;
    logic [15:0] r_a2, n_a2;
    logic        r_playing, n_playing;

    // pending results of the current request
    scsu_pkg::t_result r_slot0, n_slot0;
    scsu_pkg::t_result r_slot1, n_slot1;
    logic [1:0]        r_nres, n_nres;

    // output register
    logic              r_m_valid, n_m_valid;
    scsu_pkg::t_result r_out, n_out;
    logic              r_o_loop, n_o_loop;
    logic              r_o_run, n_o_run;
    logic              r_o_last, n_o_last;

    logic [15:0]   w_rdata;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic          w_out_busy;
    logic          w_hi_lt_lo;
    logic          w_div_start;
    logic          w_div_busy;
    logic [15:0]   w_rem;
    logic          w_accept;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_busy = r_m_valid && !m_axis_tready;
    assign w_hi_lt_lo = r_a2 < r_a1;
    assign w_div_start = (w_uop == scsu_pkg::U_RAND) && !w_hi_lt_lo;
    assign w_we       = (w_uop == scsu_pkg::U_WRITE);

    always_comb begin
        w_status.in_valid    = s_axis_tvalid;
        w_status.req_type    = r_rtype;
        w_status.running     = r_run;
        w_status.delay_nz    = (r_delay != 16'd0);
        w_status.opcode      = r_op;
        w_status.hi_lt_lo    = w_hi_lt_lo;
        w_status.div_busy    = w_div_busy;
        w_status.out_busy    = w_out_busy;
        w_status.two_results = (r_nres == 2'd2);
    end

    scsu_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uop    (w_uop)
    );

    always_comb begin
        case (w_uop)
            scsu_pkg::U_TICK: w_raddr = r_ptr;
            scsu_pkg::U_RD1:  w_raddr = ptr_add(r_ptr, 2'd1);
            default:          w_raddr = ptr_add(r_ptr, 2'd2);
        endcase
    end

    scsu_ram #(
        .WIDTH (16),
        .DEPTH (PROG_DEPTH)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (wrap_addr8(r_waddr)),
        .i_wdata (r_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    scsu_moddiv u_moddiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rnd),
        .i_divisor  ({1'b0, r_a2} - {1'b0, r_a1} + 17'd1),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    assign s_axis_tready = (w_uop == scsu_pkg::U_ACCEPT);

    always_comb begin
        scsu_pkg::t_result play_res;
        logic [1:0]        cnt;

        n_ptr     = r_ptr;
        n_base    = r_base;
        n_cur     = r_cur;
        n_vol     = r_vol;
        n_att     = r_att;
        n_delay   = r_delay;
        n_loop    = r_loop;
        n_run     = r_run;
        n_stop    = r_stop;
        n_barred  = r_barred;
        n_op      = r_op;
        n_a1      = r_a1;
        n_a2      = r_a2;
        n_playing = r_playing;
        n_slot0   = r_slot0;
        n_slot1   = r_slot1;
        n_nres    = r_nres;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_out     = r_out;
        n_o_loop  = r_o_loop;
        n_o_run   = r_o_run;
        n_o_last  = r_o_last;
        play_res  = '{scsu_pkg::ACT_NONE, 16'd0, 7'd0, 8'd0};
        cnt       = 2'd0;

        case (w_uop)
            scsu_pkg::U_ACCEPT: begin
                n_nres = 2'd0;
            end
            scsu_pkg::U_STOP_END, scsu_pkg::U_STOP_KEEP: begin
                if (r_run) begin
                    if (!r_barred) begin
                        n_slot0 = '{scsu_pkg::ACT_STOP, 16'd0, 7'd0, 8'd0};
                        cnt = 2'd1;
                    end
                    if (r_stop != 16'd0) begin
                        play_res = '{scsu_pkg::ACT_PLAY_ONCE, r_stop, r_vol[6:0], r_att};
                        if (cnt == 2'd0) begin
                            n_slot0 = play_res;
                        end else begin
                            n_slot1 = play_res;
                        end
                        cnt = cnt + 2'd1;
                    end
                    if (cnt == 2'd0 && w_uop == scsu_pkg::U_STOP_END) begin
                        n_slot0 = '{scsu_pkg::ACT_ENDED, 16'd0, 7'd0, 8'd0};
                        cnt = 2'd1;
                    end
                    n_nres  = cnt;
                    n_run   = 1'b0;
                    n_loop  = 1'b0;
                    n_cur   = 16'd0;
                    n_delay = 16'd0;
                end
            end
            scsu_pkg::U_START: begin
                n_base   = wrap_addr8(r_saddr);
                n_ptr    = wrap_addr8(r_saddr);
                n_vol    = clamp_vol({11'd0, r_svol});
                n_att    = r_satt;
                n_stop   = r_sstop;
                n_barred = r_snocut;
                n_cur    = 16'd0;
                n_delay  = 16'd0;
                n_loop   = 1'b0;
                n_run    = 1'b1;
            end
            scsu_pkg::U_TICK: begin
                // count down a pending delay; a running sequence with no delay starts fetching
                if (r_run && r_delay != 16'd0) begin
                    n_delay = r_delay - 16'd1;
                end
                n_playing = (r_cur != 16'd0) && r_sbusy;
            end
            scsu_pkg::U_RD1: n_op = w_rdata;
            scsu_pkg::U_RD2: n_a1 = w_rdata;
            scsu_pkg::U_RD3: begin
                n_a2   = w_rdata;
                n_loop = 1'b0;
            end
            scsu_pkg::U_PLAY: begin
                if (!r_playing) begin
                    n_cur = r_a1;
                    if (r_a1 != 16'd0) begin
                        n_slot0 = '{scsu_pkg::ACT_PLAY_ONCE, r_a1, r_vol[6:0], r_att};
                        n_nres = 2'd1;
                    end
                end
                n_ptr = ptr_add(r_ptr, 2'd2);
            end
            scsu_pkg::U_WAIT: begin
                if (!r_playing) begin
                    n_ptr = ptr_add(r_ptr, 2'd1);
                    n_cur = 16'd0;
                end
            end
            scsu_pkg::U_PLAY_REP: begin
                if (!r_playing) begin
                    n_cur = r_a1;
                    if (r_a1 != 16'd0) begin
                        n_slot0 = '{scsu_pkg::ACT_PLAY_REP, r_a1, r_vol[6:0], r_att};
                        n_nres = 2'd1;
                    end
                end
                n_loop = 1'b1;
            end
            scsu_pkg::U_PLAY_LOOP: begin
                n_loop  = 1'b1;
                n_delay = r_a2;
                n_cur   = r_a1;
                if (r_a1 != 16'd0) begin
                    n_slot0 = '{scsu_pkg::ACT_PLAY_ONCE, r_a1, r_vol[6:0], r_att};
                    n_nres = 2'd1;
                end
            end
            scsu_pkg::U_DELAY: begin
                n_cur   = 16'd0;
                n_delay = r_a1;
                n_ptr   = ptr_add(r_ptr, 2'd2);
            end
            scsu_pkg::U_RAND: begin
                n_cur = 16'd0;
                n_ptr = ptr_add(r_ptr, 2'd3);
                if (w_hi_lt_lo) begin
                    n_delay = r_a1;
                end
            end
            scsu_pkg::U_RAND_FIN: n_delay = r_a1 + w_rem;
            scsu_pkg::U_VOLUME: begin
                n_vol = clamp_vol({{2{r_a1[15]}}, r_a1});
                n_ptr = ptr_add(r_ptr, 2'd2);
            end
            scsu_pkg::U_VOL_REL: begin
                n_vol = clamp_vol($signed({10'd0, r_vol}) + $signed({{2{r_a1[15]}}, r_a1}));
                n_ptr = ptr_add(r_ptr, 2'd2);
            end
            scsu_pkg::U_ATTEN: begin
                n_att = r_a1[7:0];
                n_ptr = ptr_add(r_ptr, 2'd2);
            end
            scsu_pkg::U_RESTART: n_ptr = r_base;
            scsu_pkg::U_END: begin
                // with a stop sound set, hold on the end command until stopped
                if (r_stop == 16'd0) begin
                    n_slot1 = '{scsu_pkg::ACT_ENDED, 16'd0, 7'd0, 8'd0};
                    if (r_barred) begin
                        n_slot0 = '{scsu_pkg::ACT_ENDED, 16'd0, 7'd0, 8'd0};
                        n_nres = 2'd1;
                    end else begin
                        n_slot0 = '{scsu_pkg::ACT_STOP, 16'd0, 7'd0, 8'd0};
                        n_nres = 2'd2;
                    end
                    n_run  = 1'b0;
                    n_loop = 1'b0;
                    n_cur  = 16'd0;
                end
            end
            scsu_pkg::U_ERROR: begin
                n_slot0 = '{scsu_pkg::ACT_ERROR, 16'd0, 7'd0, 8'd0};
                n_nres  = 2'd1;
                n_run   = 1'b0;
                n_loop  = 1'b0;
                n_cur   = 16'd0;
                n_delay = 16'd0;
            end
            scsu_pkg::U_SEND0: begin
                if (!w_out_busy) begin
                    n_m_valid = 1'b1;
                    n_out     = (r_nres == 2'd0) ?
                                '{scsu_pkg::ACT_NONE, 16'd0, 7'd0, 8'd0} : r_slot0;
                    n_o_loop  = r_loop;
                    n_o_run   = r_run;
                    n_o_last  = (r_nres != 2'd2);
                end
            end
            scsu_pkg::U_SEND1: begin
                if (!w_out_busy) begin
                    n_m_valid = 1'b1;
                    n_out     = r_slot1;
                    n_o_loop  = r_loop;
                    n_o_run   = r_run;
                    n_o_last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_base    <= '0;
            r_cur     <= '0;
            r_vol     <= '0;
            r_att     <= '0;
            r_delay   <= '0;
            r_loop    <= 1'b0;
            r_run     <= 1'b0;
            r_stop    <= '0;
            r_barred  <= 1'b0;
            r_nres    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_base    <= n_base;
            r_cur     <= n_cur;
            r_vol     <= n_vol;
            r_att     <= n_att;
            r_delay   <= n_delay;
            r_loop    <= n_loop;
            r_run     <= n_run;
            r_stop    <= n_stop;
            r_barred  <= n_barred;
            r_nres    <= n_nres;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rtype  <= s_axis_tuser;
            r_waddr  <= s_axis_tdata[7:0];
            r_wdata  <= s_axis_tdata[23:8];
            r_saddr  <= s_axis_tdata[31:24];
            r_svol   <= s_axis_tdata[38:32];
            r_satt   <= s_axis_tdata[46:39];
            r_sstop  <= s_axis_tdata[62:47];
            r_snocut <= s_axis_tdata[63];
            r_sbusy  <= s_axis_tdata[64];
            r_rnd    <= s_axis_tdata[80:65];
        end
        r_op      <= n_op;
        r_a1      <= n_a1;
        r_a2      <= n_a2;
        r_playing <= n_playing;
        r_slot0   <= n_slot0;
        r_slot1   <= n_slot1;
        r_out     <= n_out;
        r_o_loop  <= n_o_loop;
        r_o_run   <= n_o_run;
        r_o_last  <= n_o_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {7'd0, r_o_run, r_o_loop, r_out.att, r_out.vol, r_out.sid};

endmodule

@@ hdl/scsu_checker.sv @@
`include "sound_command_sequencer_unit_macros.svh"

module scsu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             i_s_tready,
    input logic                             i_m_tvalid,
    input logic                             i_m_tready,
    input logic [scsu_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input logic [2:0]                       i_m_tuser,
    input logic                             i_m_tlast
);

    logic w_m_stall;
    logic w_non_play;
    logic w_finish;

    assign w_m_stall  = i_m_tvalid && !i_m_tready;
    assign w_non_play = i_m_tvalid && (i_m_tuser != scsu_pkg::ACT_PLAY_ONCE) &&
                        (i_m_tuser != scsu_pkg::ACT_PLAY_REP);
    assign w_finish   = i_m_tvalid && ((i_m_tuser == scsu_pkg::ACT_ENDED) ||
                        (i_m_tuser == scsu_pkg::ACT_ERROR));

    // hold a stalled result
    `SCSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_m_stall, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "stalled result changed")

    // one request at a time
    `SCSU_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready, "request accepted back to back")

    `SCSU_ASSERT_NOW(a_non_play_zero, i_clk, i_rst_n, w_non_play, i_m_tdata[30:0] == 31'd0, "non-play result carries sound fields")

    `SCSU_ASSERT_NOW(a_finish_idle, i_clk, i_rst_n, w_finish, !i_m_tdata[32], "ended or error while still active")

endmodule

bind sound_command_sequencer_unit scsu_checker u_scsu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
